### sv/gnvp_pkg.sv
// Package for the greedy nearest-value pairing block.
// Holds the sizing constants, request types, sequencer states and the compare-unit result.
// No dependencies.
package gnvp_pkg;

    // Store sizing
    localparam int MAX_PER_SEX = 32;
    localparam int ID_BITS     = 16;
    localparam int IDX_W       = (MAX_PER_SEX > 1) ? $clog2(MAX_PER_SEX) : 1;
    localparam int CNT_W       = $clog2(MAX_PER_SEX + 1);
    localparam int HYB_W       = 16;
    localparam int LIFE_W      = 3;

    // Gender codes
    localparam logic [1:0] GENDER_FEMALE = 2'd0;
    localparam logic [1:0] GENDER_MALE   = 2'd1;

    // Reset value of the fertile state register
    localparam logic [LIFE_W-1:0] FERTILE_RESET = 3'd2;

    // Input request
    typedef struct packed {
        logic [15:0]       agent_id;
        logic [1:0]        gender;
        logic [LIFE_W-1:0] life_state;
        logic [HYB_W-1:0]  hybridization;
        logic              last_of_cell;
    } t_in_req;

    // Output request
    typedef struct packed {
        logic [15:0] female_id;
        logic [15:0] male_id;
        logic        pair_valid;
        logic        dropped;
        logic        last_pair;
    } t_out_req;

    // One store entry
    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [HYB_W-1:0]   hyb;
    } t_entry;

    // Result of the shared distance/compare unit
    typedef struct packed {
        logic [HYB_W-1:0] diff;
        logic             less;
    } t_dist_res;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_RDLEAD,
        S_FIRST,
        S_SCAN,
        S_SWAP1,
        S_SWAP2,
        S_ORD,
        S_OLOAD,
        S_OWAIT
    } t_state;

endpackage

### sv/gnvp_dist.sv
// Shared distance unit: absolute hybridization difference and compare with the best so far.
// Depends on gnvp_pkg.
module gnvp_dist
    import gnvp_pkg::*;
(
    input  logic [HYB_W-1:0] i_h1,
    input  logic [HYB_W-1:0] i_h2,
    input  logic [HYB_W-1:0] i_best,
    output t_dist_res        o_res
);

    // Absolute difference, then a strict compare so the earliest entry wins a tie.
    always_comb begin
        if (i_h2 >= i_h1) begin
            o_res.diff = i_h2 - i_h1;
        end else begin
            o_res.diff = i_h1 - i_h2;
        end
        o_res.less = (o_res.diff < i_best);
    end

endmodule

### sv/greedy_nearest_value_pairing.sv
// Greedy nearest-value pairing of the fertile agents of one cell.
// Depends on gnvp_pkg and gnvp_dist.
//
// Usage: agents of a cell arrive as input requests on i_in_valid/o_in_ready.
// Fertile females and males (life_state nonzero and equal to the fertile
// state register) are written to two 32-entry stores; others are ignored,
// and agents past a full store are dropped and flagged. While idle, a new
// loading request can follow the last one without a wait. The request with
// last_of_cell set starts the pairing sequence, during which o_in_ready is low.
// Pairing runs on one distance/compare unit: for leading entry i it reads the lead
// and first partner (S_RDLEAD, S_FIRST), scans the remaining partners (S_SCAN) and
// swaps the pick into place (S_SWAP1, S_SWAP2); the cost of a cell is quadratic in
// the list length and bounded by the single store read port per list. Each pair is
// then read from the stores (S_ORD, S_OLOAD) and presented in S_OWAIT, which holds
// the output request while i_out_ready is low. A cell with no pair returns one
// marker request with pair_valid low. The fertile state register is written
// through i_cfg_we/i_cfg_wdata; the user must write it only while idle, which the
// block does not enforce. Reset clears counts, the drop flag and the sequencer;
// store contents are not cleared, since only entries below the counts are read.
module greedy_nearest_value_pairing
    import gnvp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LIFE_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_req           i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_req          o_out_req
);

    // Registers
    t_state            r_state, n_state;
    logic [LIFE_W-1:0] r_fert;
    logic [CNT_W-1:0]  r_fcnt, n_fcnt;
    logic [CNT_W-1:0]  r_mcnt, n_mcnt;
    logic              r_ovf, n_ovf;
    logic              r_lead_m, n_lead_m;
    logic [CNT_W-1:0]  r_npairs, n_npairs;
    logic [CNT_W-1:0]  r_npart, n_npart;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [IDX_W-1:0]  r_j, n_j;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [IDX_W-1:0]  r_pick, n_pick;
    logic [HYB_W-1:0]  r_h1, n_h1;
    logic [HYB_W-1:0]  r_best, n_best;
    t_entry            r_best_ent, n_best_ent;
    t_entry            r_ent_i, n_ent_i;
    t_out_req          r_out, n_out;
    logic              r_ovalid, n_ovalid;

    // Store memories and their registered read data
    t_entry            r_fmem [MAX_PER_SEX];
    t_entry            r_mmem [MAX_PER_SEX];
    t_entry            r_frd, r_mrd;

    // Memory port controls
    logic [IDX_W-1:0]  f_addr, m_addr;
    logic              f_we, m_we;
    t_entry            f_wdata, m_wdata;

    // Role-based controls, mapped onto the stores below
    logic [IDX_W-1:0]  lead_addr, part_addr;
    logic              part_we;
    t_entry            part_wdata;
    t_entry            lead_rd, part_rd;

    // Other combinational signals
    logic              in_acc;
    logic              fertile;
    logic [CNT_W-1:0]  nxt;
    logic [HYB_W-1:0]  dist_h1;
    t_dist_res         cmp_res;
    t_entry            new_ent;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_req   = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign fertile     = (i_in_req.life_state != '0) && (i_in_req.life_state == r_fert);
    assign lead_rd     = r_lead_m ? r_mrd : r_frd;
    assign part_rd     = r_lead_m ? r_frd : r_mrd;
    assign dist_h1     = (r_state == S_FIRST) ? lead_rd.hyb : r_h1;

    always_comb begin
        new_ent.id  = ID_BITS'(i_in_req.agent_id);
        new_ent.hyb = i_in_req.hybridization;
    end

    // Shared distance and compare unit
    gnvp_dist u_dist (
        .i_h1   (dist_h1),
        .i_h2   (part_rd.hyb),
        .i_best (r_best),
        .o_res  (cmp_res)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fert <= FERTILE_RESET;
        end else if (i_cfg_we) begin
            r_fert <= i_cfg_wdata;
        end
    end

    // Store memories: one write and one registered read each per cycle
    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_fmem[f_addr] <= f_wdata;
        end
        r_frd <= r_fmem[f_addr];
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mmem[m_addr] <= m_wdata;
        end
        r_mrd <= r_mmem[m_addr];
    end

    // Control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fcnt   <= '0;
            r_mcnt   <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fcnt   <= n_fcnt;
            r_mcnt   <= n_mcnt;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_lead_m   <= n_lead_m;
        r_npairs   <= n_npairs;
        r_npart    <= n_npart;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_pick     <= n_pick;
        r_h1       <= n_h1;
        r_best     <= n_best;
        r_best_ent <= n_best_ent;
        r_ent_i    <= n_ent_i;
        r_out      <= n_out;
    end

    // Sequencer: next state and datapath controls
    always_comb begin
        n_state    = r_state;
        n_fcnt     = r_fcnt;
        n_mcnt     = r_mcnt;
        n_ovf      = r_ovf;
        n_ovalid   = r_ovalid;
        n_lead_m   = r_lead_m;
        n_npairs   = r_npairs;
        n_npart    = r_npart;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_pick     = r_pick;
        n_h1       = r_h1;
        n_best     = r_best;
        n_best_ent = r_best_ent;
        n_ent_i    = r_ent_i;
        n_out      = r_out;
        lead_addr  = '0;
        part_addr  = '0;
        part_we    = 1'b0;
        part_wdata = r_ent_i;
        nxt        = '0;
        f_addr     = '0;
        m_addr     = '0;
        f_we       = 1'b0;
        m_we       = 1'b0;
        f_wdata    = new_ent;
        m_wdata    = new_ent;

        unique case (r_state)
            S_IDLE: begin
                // Load a fertile agent into its store, or flag the drop.
                if (in_acc) begin
                    if (fertile && i_in_req.gender == GENDER_FEMALE) begin
                        if (r_fcnt < CNT_W'(MAX_PER_SEX)) begin
                            f_addr = r_fcnt[IDX_W-1:0];
                            f_we   = 1'b1;
                            n_fcnt = r_fcnt + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (fertile && i_in_req.gender == GENDER_MALE) begin
                        if (r_mcnt < CNT_W'(MAX_PER_SEX)) begin
                            m_addr = r_mcnt[IDX_W-1:0];
                            m_we   = 1'b1;
                            n_mcnt = r_mcnt + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (i_in_req.last_of_cell) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                // The shorter list leads; males lead on a tie.
                n_lead_m = !(r_fcnt < r_mcnt);
                n_npairs = (r_fcnt < r_mcnt) ? r_fcnt : r_mcnt;
                n_npart  = (r_fcnt < r_mcnt) ? r_mcnt : r_fcnt;
                n_i      = '0;
                if (n_npairs == '0) begin
                    n_out.female_id  = '0;
                    n_out.male_id    = '0;
                    n_out.pair_valid = 1'b0;
                    n_out.dropped    = r_ovf;
                    n_out.last_pair  = 1'b1;
                    n_ovalid         = 1'b1;
                    n_state          = S_OWAIT;
                end else begin
                    n_state = S_RDLEAD;
                end
            end
            S_RDLEAD: begin
                lead_addr = r_i;
                part_addr = r_i;
                n_state   = S_FIRST;
            end
            S_FIRST: begin
                // The first scanned partner is always taken as the initial best.
                n_h1       = lead_rd.hyb;
                n_ent_i    = part_rd;
                n_best_ent = part_rd;
                n_best     = cmp_res.diff;
                n_pick     = r_i;
                nxt        = CNT_W'(r_i) + 1'b1;
                if (nxt < r_npart) begin
                    part_addr = nxt[IDX_W-1:0];
                    n_j       = nxt[IDX_W-1:0];
                    n_state   = S_SCAN;
                end else begin
                    n_state = S_SWAP1;
                end
            end
            S_SCAN: begin
                // Data of entry r_j is here; issue the next read.
                if (cmp_res.less) begin
                    n_best     = cmp_res.diff;
                    n_best_ent = part_rd;
                    n_pick     = r_j;
                end
                nxt = CNT_W'(r_j) + 1'b1;
                if (nxt < r_npart) begin
                    part_addr = nxt[IDX_W-1:0];
                    n_j       = nxt[IDX_W-1:0];
                end else begin
                    n_state = S_SWAP1;
                end
            end
            S_SWAP1: begin
                part_addr  = r_pick;
                part_we    = 1'b1;
                part_wdata = r_ent_i;
                n_state    = S_SWAP2;
            end
            S_SWAP2: begin
                part_addr  = r_i;
                part_we    = 1'b1;
                part_wdata = r_best_ent;
                nxt        = CNT_W'(r_i) + 1'b1;
                if (nxt < r_npairs) begin
                    n_i     = nxt[IDX_W-1:0];
                    n_state = S_RDLEAD;
                end else begin
                    n_k     = '0;
                    n_state = S_ORD;
                end
            end
            S_ORD: begin
                f_addr  = r_k;
                m_addr  = r_k;
                n_state = S_OLOAD;
            end
            S_OLOAD: begin
                nxt              = CNT_W'(r_k) + 1'b1;
                n_out.female_id  = 16'(r_frd.id);
                n_out.male_id    = 16'(r_mrd.id);
                n_out.pair_valid = 1'b1;
                n_out.dropped    = r_ovf;
                n_out.last_pair  = (nxt == r_npairs);
                n_ovalid         = 1'b1;
                n_state          = S_OWAIT;
            end
            S_OWAIT: begin
                // Hold the result until the receiver takes it.
                if (i_out_ready) begin
                    n_ovalid = 1'b0;
                    if (r_out.last_pair) begin
                        n_fcnt  = '0;
                        n_mcnt  = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Map lead and partner roles onto the two stores while pairing.
        if (r_state == S_RDLEAD || r_state == S_FIRST || r_state == S_SCAN ||
            r_state == S_SWAP1 || r_state == S_SWAP2) begin
            if (r_lead_m) begin
                m_addr  = lead_addr;
                f_addr  = part_addr;
                f_we    = part_we;
                f_wdata = part_wdata;
            end else begin
                f_addr  = lead_addr;
                m_addr  = part_addr;
                m_we    = part_we;
                m_wdata = part_wdata;
            end
        end
    end

    // Input is never taken while a result is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready))
        else $error("input accepted while a result is pending");

    // Store counts never pass the store depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fcnt <= CNT_W'(MAX_PER_SEX)) && (r_mcnt <= CNT_W'(MAX_PER_SEX)))
        else $error("store count beyond depth");

    // The scan index stays inside the partner list.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_j) < r_npart))
        else $error("scan past partner list");

    // The final result of a cell clears counts and the drop flag.
    a_cell_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_req.last_pair) |=>
        (r_fcnt == '0 && r_mcnt == '0 && !r_ovf && o_in_ready))
        else $error("cell state not cleared after final result");

endmodule
